[rtl/assert_macros.svh]
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ECS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecs assertion failed");

// Next-cycle implication, checked outside reset.
`define ECS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecs assertion failed");

`endif

[rtl/ecs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ecs_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CHAR_PCT    = 8'h25;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_USCORE = 8'h5F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_LBRACK = 8'h5B;
  localparam logic [7:0] MAX_DECODED = 8'h7F;

  typedef struct packed {
    logic [7:0] in_char;
    logic       final_char;
  } src_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_end;
  } dst_item_t;

  typedef struct packed {
    logic       keep;
    logic [6:0] ch;
  } slot_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][6:0] chars;
    logic [CNT_W-1:0]            count;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_val(input logic [7:0] b);
    hex_t h;
    h = '0;
    if (b inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = b[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic slot_t clean_char(input logic [7:0] ch);
    slot_t s;
    s.keep = 1'b0;
    s.ch   = ch[6:0];
    if (ch inside {[8'h09:8'h0D], 8'h20}) begin
      s.keep = 1'b1;
      s.ch   = CHAR_USCORE[6:0];
    end else if (ch inside {[8'h21:8'h7E]} &&
                 !(ch inside {CHAR_BSLASH, CHAR_STAR, CHAR_QMARK,
                              CHAR_COMMA, CHAR_COLON, CHAR_LBRACK})) begin
      s.keep = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/escaped_name_char_sanitizer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Percent-decoding name sanitizer. Takes one byte of an encoded name per
// item (final_char marks the last byte) and gives zero to three cleaned
// printable characters per byte, run_end set on the last one. Items are
// accepted one per cycle while src_stall is low; each result is registered
// first in the queue, then in the output register. Results leave through
// a single output register at one per cycle while dst_stall is low, so a
// byte that expands to k results occupies the output until all k leave;
// a queue of QueueDepth expanded bytes between the decoder and the
// output stage absorbs such bursts before src_stall rises.
module escaped_name_char_sanitizer_unit #(
  parameter int QueueDepth = ecs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  ecs_pkg::src_item_t src_item,
  output logic               dst_valid,
  input  logic               dst_stall,
  output ecs_pkg::dst_item_t dst_item
);
  import ecs_pkg::*;

  logic      push;
  logic      pop;
  job_t      job;
  job_t      head;
  q_status_t q_status;

  ecs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .valid    (src_valid),
    .stall    (src_stall),
    .item     (src_item),
    .q_status (q_status),
    .push     (push),
    .job      (job)
  );

  ecs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ecs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .valid    (dst_valid),
    .stall    (dst_stall),
    .item     (dst_item)
  );

endmodule

`default_nettype wire

[rtl/ecs_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ecs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  ecs_pkg::src_item_t item,
  input  ecs_pkg::q_status_t q_status,
  output logic              push,
  output ecs_pkg::job_t     job
);
  import ecs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;

  logic       last;
  logic [7:0] b;
  hex_t       hx;
  hex_t       held_hx;
  logic [7:0] decoded;
  logic       fresh_hold;
  slot_t      fresh_slot;
  slot_t      cand [MAX_RESULTS];
  logic [CNT_W-1:0] n;

  assign b       = item.in_char;
  assign last    = item.final_char;
  assign hx      = hex_val(b);
  assign held_hx = hex_val(held_digit);
  assign decoded = {held_hx.val, hx.val};

  assign fresh_hold = (b == CHAR_PCT) && !last;

  always_comb begin
    if (fresh_hold) begin
      fresh_slot = '0;
    end else if (b == CHAR_DOT && last) begin
      fresh_slot = clean_char(CHAR_USCORE);
    end else begin
      fresh_slot = clean_char(b);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      cand[i] = '0;
    end
    phase_next      = fresh_hold ? PH_PCT : PH_IDLE;
    held_digit_next = held_digit;
    case (phase)
      PH_PCT: begin
        if (hx.ok && !last) begin
          phase_next      = PH_DIGIT;
          held_digit_next = b;
        end else begin
          cand[0] = clean_char(CHAR_PCT);
          cand[1] = fresh_slot;
        end
      end
      PH_DIGIT: begin
        held_digit_next = '0;
        if (hx.ok && held_hx.ok && decoded <= MAX_DECODED) begin
          phase_next = PH_IDLE;
          cand[0]    = (decoded == CHAR_DOT && last) ? clean_char(CHAR_USCORE)
                                                     : clean_char(decoded);
        end else begin
          cand[0] = clean_char(CHAR_PCT);
          cand[1] = clean_char(held_digit);
          cand[2] = fresh_slot;
        end
      end
      default: begin
        cand[0] = fresh_slot;
      end
    endcase
    if (last) begin
      phase_next      = PH_IDLE;
      held_digit_next = '0;
    end
  end

  // Pack kept characters to the front of the job.
  always_comb begin
    n   = '0;
    job = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (cand[i].keep) begin
        job.chars[n[1:0]] = cand[i].ch;
        n = n + 1'b1;
      end
    end
    job.count = n;
  end

  assign stall = q_status.full;
  assign push  = valid && !stall && (job.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= '0;
    end else if (valid && !stall) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

`default_nettype wire

[rtl/ecs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ecs_queue #(
  parameter int Depth = ecs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ecs_pkg::job_t      push_job,
  input  logic               pop,
  output ecs_pkg::job_t      head,
  output ecs_pkg::q_status_t status
);
  import ecs_pkg::*;

  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FillW = $clog2(Depth + 1);

  job_t             slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [FillW-1:0] fill;

  assign head         = slots[rd_ptr];
  assign status.empty = (fill == '0);
  assign status.full  = (fill == FillW'(Depth));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ecs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ecs_back (
  input  logic               clk,
  input  logic               rst,
  input  ecs_pkg::job_t      head,
  input  ecs_pkg::q_status_t q_status,
  output logic               pop,
  output logic               valid,
  input  logic               stall,
  output ecs_pkg::dst_item_t item
);
  import ecs_pkg::*;

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             last_slot;

  assign load      = !valid || !stall;
  assign last_slot = (idx == head.count - 1'b1);
  assign pop       = load && !q_status.empty && last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= !q_status.empty;
      if (!q_status.empty) begin
        item.out_char <= head.chars[idx[1:0]];
        item.run_end  <= last_slot;
        idx           <= last_slot ? '0 : idx + 1'b1;
      end
    end
  end

  `ECS_ASSERT_IMPL(a_char_printable, clk, rst, valid, (item.out_char >= 7'h21) && (item.out_char <= 7'h7E))
  `ECS_ASSERT_IMPL(a_idx_in_job, clk, rst, !q_status.empty, (head.count != '0) && (idx < head.count))
  `ECS_ASSERT_NEXT(a_run_continues, clk, rst, valid && !stall && !item.run_end, valid)

endmodule

`default_nettype wire
